### rtl/ffa_pkg.sv
// Package for the first-fit free-list allocator: constants, codes and the
// request/response transaction types.
// No dependencies.
`default_nettype none

package ffa_pkg;

   localparam int HeapUnits      = 4096;
   localparam int UnitBytes      = 16;
   localparam int MinRegionReset = 1024;

   localparam int ModeW   = 2;
   localparam int ByteW   = 17;
   localparam int AddrW   = 12;
   localparam int StatusW = 3;

   localparam logic [ModeW-1:0] ModeAlloc = 2'd0;
   localparam logic [ModeW-1:0] ModeFree  = 2'd1;
   localparam logic [ModeW-1:0] ModeAdd   = 2'd2;

   localparam logic [StatusW-1:0] StatOk       = 3'd0;
   localparam logic [StatusW-1:0] StatBadSize  = 3'd1;
   localparam logic [StatusW-1:0] StatNoSpace  = 3'd2;
   localparam logic [StatusW-1:0] StatBadBlock = 3'd3;
   localparam logic [StatusW-1:0] StatShort    = 3'd4;

   typedef struct packed {
      logic [ModeW-1:0] mode;
      logic [ByteW-1:0] byte_count;
      logic [AddrW-1:0] unit_address;
   } ffa_req_type;

   typedef struct packed {
      logic [AddrW-1:0]   payload_unit;
      logic [StatusW-1:0] status;
   } ffa_rsp_type;

endpackage

`default_nettype wire

### rtl/first_fit_free_list_allocator.sv
// First-fit free-list allocator with address-ordered coalescing.
// Depends on ffa_pkg, ffa_store, ffa_ctrl.
//
// Usage:
//  - Command channel: a transaction is taken at a clock edge with start high
//    and busy low; req_data carries mode, byte_count and unit_address.
//  - Each transaction gives exactly one response: rsp_valid is high for one
//    cycle with rsp_data (payload_unit, status). The receiver cannot stall.
//  - csr_write_enable/csr_write_data write min_region_bytes; write only
//    while busy is low.
//  - Sequence: rejects answer in the cycle after start. Allocate walks free
//    blocks, plus a write state when the block is carved; free reads the
//    block header, then free and add region walk the list, plus a node
//    read when merging with the following block. Each list node costs one
//    memory read (address plus data state). One transaction at a time;
//    busy falls in the response cycle, where a new start is already taken.
//  - Reset (synchronous): empty free list, rover at the sentinel,
//    min_region_bytes = 1024. Memory contents are not cleared.
`default_nettype none

module first_fit_free_list_allocator #(
   parameter int HEAP_UNITS = ffa_pkg::HeapUnits,
   parameter int UNIT_BYTES = ffa_pkg::UnitBytes
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  ffa_pkg::ffa_req_type         req_data,
   output logic                         rsp_valid,
   output ffa_pkg::ffa_rsp_type         rsp_data,
   input  wire                          csr_write_enable,
   input  wire  [ffa_pkg::ByteW-1:0]    csr_write_data
);

   localparam int AW = $clog2(HEAP_UNITS);
   localparam int IW = $clog2(HEAP_UNITS + 1);

   logic [ffa_pkg::ByteW-1:0] min_region_ff, min_region_in;

   logic [AW-1:0] rd_addr, wr_addr;
   logic [IW-1:0] rd_size, rd_link, wr_size, wr_link;
   logic          wr_size_en, wr_link_en;

   assign min_region_in = csr_write_enable ? csr_write_data : min_region_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_region_ff <= ffa_pkg::ByteW'(ffa_pkg::MinRegionReset);
      end else begin
         min_region_ff <= min_region_in;
      end
   end

   ffa_store #(
      .HEAP_UNITS (HEAP_UNITS)
   ) u_store (
      .clock      (clock),
      .rd_addr    (rd_addr),
      .rd_size    (rd_size),
      .rd_link    (rd_link),
      .wr_addr    (wr_addr),
      .wr_size_en (wr_size_en),
      .wr_link_en (wr_link_en),
      .wr_size    (wr_size),
      .wr_link    (wr_link)
   );

   ffa_ctrl #(
      .HEAP_UNITS (HEAP_UNITS),
      .UNIT_BYTES (UNIT_BYTES)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .min_region     (min_region_ff),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .mem_rd_addr    (rd_addr),
      .mem_rd_size    (rd_size),
      .mem_rd_link    (rd_link),
      .mem_wr_addr    (wr_addr),
      .mem_wr_size_en (wr_size_en),
      .mem_wr_link_en (wr_link_en),
      .mem_wr_size    (wr_size),
      .mem_wr_link    (wr_link)
   );

endmodule

`default_nettype wire

### rtl/ffa_store.sv
// Block size and next-link memories of the allocator, one read address
// shared by both arrays, registered read data, one write address.
// No package dependency.
`default_nettype none

module ffa_store #(
   parameter int HEAP_UNITS = 4096
) (
   input  wire                                  clock,
   input  wire  [$clog2(HEAP_UNITS)-1:0]        rd_addr,
   output logic [$clog2(HEAP_UNITS+1)-1:0]      rd_size,
   output logic [$clog2(HEAP_UNITS+1)-1:0]      rd_link,
   input  wire  [$clog2(HEAP_UNITS)-1:0]        wr_addr,
   input  wire                                  wr_size_en,
   input  wire                                  wr_link_en,
   input  wire  [$clog2(HEAP_UNITS+1)-1:0]      wr_size,
   input  wire  [$clog2(HEAP_UNITS+1)-1:0]      wr_link
);

   localparam int IW = $clog2(HEAP_UNITS + 1);

   logic [IW-1:0] size_mem [HEAP_UNITS];
   logic [IW-1:0] link_mem [HEAP_UNITS];

   always_ff @(posedge clock) begin
      if (wr_size_en) begin
         size_mem[wr_addr] <= wr_size;
      end
      rd_size <= size_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_link_en) begin
         link_mem[wr_addr] <= wr_link;
      end
      rd_link <= link_mem[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/ffa_ctrl.sv
// Sequencer of the allocator: list walks, splitting, coalescing, rover and
// sentinel link. Drives the ffa_store memory ports.
// Depends on ffa_pkg.
`default_nettype none

module ffa_ctrl #(
   parameter int HEAP_UNITS = ffa_pkg::HeapUnits,
   parameter int UNIT_BYTES = ffa_pkg::UnitBytes
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   output logic                                 busy,
   input  ffa_pkg::ffa_req_type                 req_data,
   input  wire  [ffa_pkg::ByteW-1:0]            min_region,
   output logic                                 rsp_valid,
   output ffa_pkg::ffa_rsp_type                 rsp_data,
   output logic [$clog2(HEAP_UNITS)-1:0]        mem_rd_addr,
   input  wire  [$clog2(HEAP_UNITS+1)-1:0]      mem_rd_size,
   input  wire  [$clog2(HEAP_UNITS+1)-1:0]      mem_rd_link,
   output logic [$clog2(HEAP_UNITS)-1:0]        mem_wr_addr,
   output logic                                 mem_wr_size_en,
   output logic                                 mem_wr_link_en,
   output logic [$clog2(HEAP_UNITS+1)-1:0]      mem_wr_size,
   output logic [$clog2(HEAP_UNITS+1)-1:0]      mem_wr_link
);

   localparam int AW      = $clog2(HEAP_UNITS);
   localparam int IW      = $clog2(HEAP_UNITS + 1);
   localparam int SW      = ffa_pkg::ByteW + 1;
   localparam int CW      = $clog2(HEAP_UNITS + 3);
   localparam int PW      = ffa_pkg::AddrW;
   localparam int UbShift = $clog2(UNIT_BYTES);   // UNIT_BYTES is a power of two

   localparam logic [IW-1:0] Sent      = IW'(HEAP_UNITS);
   localparam logic [CW-1:0] WalkLimit = CW'(HEAP_UNITS + 2);

   localparam logic [3:0] StIdle = 4'd0;
   localparam logic [3:0] StGw0  = 4'd1;
   localparam logic [3:0] StGe0  = 4'd2;
   localparam logic [3:0] StGw   = 4'd3;
   localparam logic [3:0] StGe   = 4'd4;
   localparam logic [3:0] StGc   = 4'd5;
   localparam logic [3:0] StFw   = 4'd6;
   localparam logic [3:0] StFe   = 4'd7;
   localparam logic [3:0] StRc   = 4'd8;
   localparam logic [3:0] StRw   = 4'd9;
   localparam logic [3:0] StRe   = 4'd10;
   localparam logic [3:0] StAw   = 4'd11;
   localparam logic [3:0] StAe   = 4'd12;
   localparam logic [3:0] StWh   = 4'd13;
   localparam logic [3:0] StWa   = 4'd14;

   logic [3:0]    state_ff, state_in;
   logic [SW-1:0] need_ff, need_in;
   logic [SW-1:0] hdr_ff, hdr_in;
   logic [SW-1:0] len_ff, len_in;
   logic [IW-1:0] prev_ff, prev_in;
   logic [IW-1:0] node_ff, node_in;
   logic [CW-1:0] steps_ff, steps_in;
   logic [IW-1:0] size_at_ff, size_at_in;
   logic [IW-1:0] hsize_ff, hsize_in;
   logic [IW-1:0] hlink_ff, hlink_in;
   logic [IW-1:0] carve_ff, carve_in;
   logic [IW-1:0] rover_ff, rover_in;
   logic [IW-1:0] sent_next_ff, sent_next_in;
   logic          rsp_valid_ff, rsp_valid_in;
   ffa_pkg::ffa_rsp_type rsp_ff, rsp_in;

   logic [IW-1:0]               size_v, link_v, rem;
   logic [ffa_pkg::ByteW-1:0]   quot;
   logic [SW-1:0]               at_w, af_w, free_hdr;
   logic                        brk, fin;
   logic [ffa_pkg::StatusW-1:0] fin_status;
   logic [PW-1:0]               fin_unit;

   // sentinel reads as size zero, link from its own register
   always_comb begin
      if (node_ff >= Sent) begin
         size_v = '0;
         link_v = sent_next_ff;
      end else begin
         size_v = mem_rd_size;
         link_v = (mem_rd_link > Sent) ? Sent : mem_rd_link;
      end
   end

   assign mem_rd_addr = node_ff[AW-1:0];
   assign busy        = (state_ff != StIdle);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      need_in      = need_ff;
      hdr_in       = hdr_ff;
      len_in       = len_ff;
      prev_in      = prev_ff;
      node_in      = node_ff;
      steps_in     = steps_ff;
      size_at_in   = size_at_ff;
      hsize_in     = hsize_ff;
      hlink_in     = hlink_ff;
      carve_in     = carve_ff;
      rover_in     = rover_ff;
      sent_next_in = sent_next_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_wr_addr    = '0;
      mem_wr_size_en = 1'b0;
      mem_wr_link_en = 1'b0;
      mem_wr_size    = '0;
      mem_wr_link    = '0;
      fin        = 1'b0;
      fin_status = ffa_pkg::StatOk;
      fin_unit   = '0;
      quot       = req_data.byte_count >> UbShift;
      free_hdr   = SW'(req_data.unit_address) - SW'(1);
      rem        = size_v - IW'(need_ff);
      at_w       = SW'(node_ff);
      af_w       = SW'(link_v);
      brk        = (hdr_ff > at_w && hdr_ff < af_w) ||
                   (at_w >= af_w && (hdr_ff > at_w || hdr_ff < af_w));

      case (state_ff)
         StIdle: begin
            if (start) begin
               case (req_data.mode)
                  ffa_pkg::ModeAlloc: begin
                     if (req_data.byte_count == '0) begin
                        fin        = 1'b1;
                        fin_status = ffa_pkg::StatBadSize;
                     end else begin
                        need_in  = ((SW'(req_data.byte_count) + SW'(UNIT_BYTES - 1))
                                    >> UbShift) + SW'(1);
                        node_in  = rover_ff;
                        state_in = StGw0;
                     end
                  end
                  ffa_pkg::ModeFree: begin
                     if (req_data.unit_address == '0 || free_hdr >= SW'(Sent)) begin
                        fin        = 1'b1;
                        fin_status = ffa_pkg::StatBadBlock;
                     end else begin
                        hdr_in   = free_hdr;
                        node_in  = IW'(free_hdr);
                        state_in = StFw;
                     end
                  end
                  ffa_pkg::ModeAdd: begin
                     if (req_data.byte_count < min_region) begin
                        fin        = 1'b1;
                        fin_status = ffa_pkg::StatShort;
                     end else if (quot < ffa_pkg::ByteW'(2)) begin
                        fin        = 1'b1;
                        fin_status = ffa_pkg::StatBadBlock;
                     end else begin
                        hdr_in   = SW'(req_data.unit_address);
                        len_in   = SW'(quot) - SW'(1);
                        state_in = StRc;
                     end
                  end
                  default: begin
                     fin        = 1'b1;
                     fin_status = ffa_pkg::StatBadSize;
                  end
               endcase
            end
         end
         StGw0: state_in = StGe0;
         StGe0: begin
            prev_in  = rover_ff;
            node_in  = link_v;
            steps_in = '0;
            state_in = StGw;
         end
         StGw: state_in = StGe;
         StGe: begin
            if (node_ff != Sent && SW'(size_v) >= need_ff) begin
               rover_in = prev_ff;
               if (SW'(size_v) == need_ff) begin
                  if (prev_ff == Sent) begin
                     sent_next_in = link_v;
                  end else begin
                     mem_wr_link_en = 1'b1;
                     mem_wr_addr    = prev_ff[AW-1:0];
                     mem_wr_link    = link_v;
                  end
                  fin      = 1'b1;
                  fin_unit = PW'(node_ff + IW'(1));
               end else begin
                  // keep the head of the block, hand out its tail
                  mem_wr_size_en = 1'b1;
                  mem_wr_addr    = node_ff[AW-1:0];
                  mem_wr_size    = rem;
                  carve_in       = node_ff + rem;
                  state_in       = StGc;
               end
            end else if (node_ff == rover_ff || steps_ff == WalkLimit - CW'(1)) begin
               fin        = 1'b1;
               fin_status = ffa_pkg::StatNoSpace;
            end else begin
               prev_in  = node_ff;
               node_in  = link_v;
               steps_in = steps_ff + CW'(1);
               state_in = StGw;
            end
         end
         StGc: begin
            mem_wr_size_en = 1'b1;
            mem_wr_addr    = carve_ff[AW-1:0];
            mem_wr_size    = IW'(need_ff);
            fin            = 1'b1;
            fin_unit       = PW'(carve_ff + IW'(1));
         end
         StFw: state_in = StFe;
         StFe: begin
            len_in   = SW'(size_v);
            state_in = StRc;
         end
         StRc: begin
            if (len_ff == '0 || hdr_ff >= SW'(Sent) || len_ff > SW'(Sent) - hdr_ff) begin
               fin        = 1'b1;
               fin_status = ffa_pkg::StatBadBlock;
            end else begin
               node_in  = rover_ff;
               steps_in = '0;
               state_in = StRw;
            end
         end
         StRw: state_in = StRe;
         StRe: begin
            if (brk) begin
               if ((node_ff != Sent && at_w + SW'(size_v) > hdr_ff) ||
                   (link_v != Sent && hdr_ff + len_ff > af_w)) begin
                  fin        = 1'b1;
                  fin_status = ffa_pkg::StatBadBlock;
               end else begin
                  prev_in    = node_ff;
                  size_at_in = size_v;
                  if (link_v != Sent && hdr_ff + len_ff == af_w) begin
                     node_in  = link_v;
                     state_in = StAw;
                  end else begin
                     hsize_in = IW'(len_ff);
                     hlink_in = link_v;
                     state_in = StWh;
                  end
               end
            end else if (steps_ff == WalkLimit) begin
               fin        = 1'b1;
               fin_status = ffa_pkg::StatBadBlock;
            end else begin
               node_in  = link_v;
               steps_in = steps_ff + CW'(1);
               state_in = StRw;
            end
         end
         StAw: state_in = StAe;
         StAe: begin
            hsize_in = IW'(len_ff) + size_v;
            hlink_in = link_v;
            state_in = StWh;
         end
         StWh: begin
            mem_wr_size_en = 1'b1;
            mem_wr_link_en = 1'b1;
            mem_wr_addr    = hdr_ff[AW-1:0];
            mem_wr_size    = hsize_ff;
            mem_wr_link    = hlink_ff;
            state_in       = StWa;
         end
         StWa: begin
            if (prev_ff != Sent && SW'(prev_ff) + SW'(size_at_ff) == hdr_ff) begin
               mem_wr_size_en = 1'b1;
               mem_wr_link_en = 1'b1;
               mem_wr_addr    = prev_ff[AW-1:0];
               mem_wr_size    = size_at_ff + hsize_ff;
               mem_wr_link    = hlink_ff;
            end else if (prev_ff == Sent) begin
               sent_next_in = IW'(hdr_ff);
            end else begin
               mem_wr_link_en = 1'b1;
               mem_wr_addr    = prev_ff[AW-1:0];
               mem_wr_link    = IW'(hdr_ff);
            end
            rover_in = prev_ff;
            fin      = 1'b1;
         end
         default: state_in = StIdle;
      endcase

      if (fin) begin
         state_in            = StIdle;
         rsp_valid_in        = 1'b1;
         rsp_in.status       = fin_status;
         rsp_in.payload_unit = (fin_status == ffa_pkg::StatOk) ? fin_unit : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rover_ff     <= Sent;
         sent_next_ff <= Sent;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rover_ff     <= rover_in;
         sent_next_ff <= sent_next_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      need_ff    <= need_in;
      hdr_ff     <= hdr_in;
      len_ff     <= len_in;
      prev_ff    <= prev_in;
      node_ff    <= node_in;
      steps_ff   <= steps_in;
      size_at_ff <= size_at_in;
      hsize_ff   <= hsize_in;
      hlink_ff   <= hlink_in;
      carve_ff   <= carve_in;
      rsp_ff     <= rsp_in;
   end

endmodule

`default_nettype wire

### rtl/ffa_check.sv
// Port-level checks for the allocator, bound to the top level.
// Depends on ffa_pkg and first_fit_free_list_allocator.
`default_nettype none

module ffa_check (
   input wire                  clock,
   input wire                  reset,
   input wire                  start,
   input wire                  busy,
   input ffa_pkg::ffa_rsp_type rsp_data,
   input wire                  rsp_valid
);

   // the response cycle is always an idle cycle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   // finishing a transaction always shows its response
   a_fall_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy fell without a response");

   a_unit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ffa_pkg::StatOk |-> rsp_data.payload_unit == '0)
      else $error("nonzero payload on failed transaction");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ffa_pkg::StatShort)
      else $error("undefined status code");

   // a response only follows an accepted transaction or a busy period
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) || $past(start))
      else $error("response without a transaction");

endmodule

bind first_fit_free_list_allocator ffa_check u_ffa_check (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid)
);

`default_nettype wire
